// ----- sv/cscv_pkg.sv -----
// ----------------------------------------------------------------------------
// cscv_pkg: shared types and constants
// Mode codes, the CORDIC arctangent table and the per-stage control word.
// ----------------------------------------------------------------------------
package cscv_pkg;

	localparam int CORDIC_STEPS = 30;
	localparam int ISQRT_STEPS  = 32;
	localparam int NUM_CELLS    = ISQRT_STEPS;
	localparam int ZW           = 34;
	localparam int OUT_W        = 33;

	localparam logic [2:0] MODE_REAL  = 3'd0;
	localparam logic [2:0] MODE_IMAG  = 3'd1;
	localparam logic [2:0] MODE_PHASE = 3'd2;
	localparam logic [2:0] MODE_AMPL  = 3'd3;
	localparam logic [2:0] MODE_INTEN = 3'd4;
	localparam logic [2:0] MODE_RESET = MODE_AMPL;

	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic [OUT_W-1:0] OUT_MAX = 33'h0_FFFF_FFFF;

	// arctan(2^-i) in Q.30 radians
	localparam logic [31:0] ATAN_Q30 [CORDIC_STEPS] = '{
		32'd843314856, 32'd497837829, 32'd263043836, 32'd133525158, 32'd67021686,
		32'd33543515, 32'd16775850, 32'd8388437, 32'd4194282, 32'd2097149,
		32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536,
		32'd32768, 32'd16384, 32'd8192, 32'd4096, 32'd2048,
		32'd1024, 32'd512, 32'd256, 32'd128, 32'd64,
		32'd32, 32'd16, 32'd8, 32'd4, 32'd2
	};

	typedef struct packed {
		logic       valid;
		logic       last;
		logic [2:0] mode;
		logic       zero;   // both parts zero: phase is 0
		logic       sat;    // sum of squares too large for amplitude
	} cell_ctrl_t;

endpackage

// ----- sv/cscv_if.sv -----
// ----------------------------------------------------------------------------
// cscv_if: stream channels
// Pixel input, view output and mode write channels with valid/ready.
// ----------------------------------------------------------------------------
interface cscv_pix_if #(parameter int SAMPLE_WIDTH = 16);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] real_part;
	logic signed [SAMPLE_WIDTH-1:0] imag_part;
	logic                           last_pixel;
	modport source (output valid, real_part, imag_part, last_pixel, input ready);
	modport sink (input valid, real_part, imag_part, last_pixel, output ready);
endinterface

interface cscv_view_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] view_value;
	logic               last_out;
	modport source (output valid, view_value, last_out, input ready);
	modport sink (input valid, view_value, last_out, output ready);
endinterface

interface cscv_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] view_mode;
	modport source (output valid, view_mode, input ready);
	modport sink (input valid, view_mode, output ready);
endinterface

// ----- sv/complex_sample_to_real_view_core.sv -----
// Path from pixel request to view request: 2 front stages,
//   32 chain cells, 1 output register.
// Throughput: one pixel per cycle; the whole pipe advances together and
//   holds while the output register is full and not taken.
// Reset: arst_n clears all valid flags and sets the mode to amplitude.
// ----------------------------------------------------------------------------
// complex_sample_to_real_view_core: complex pixel to real view
// Real, imaginary, phase (CORDIC), amplitude (restoring square root) or
// intensity of each pixel, selected by the view mode register.
// ----------------------------------------------------------------------------
module complex_sample_to_real_view_core #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	cscv_pix_if.sink         pix,
	cscv_view_if.source      view,
	cscv_cfg_if.sink         cfg
);
	import cscv_pkg::*;

	localparam int SW  = SAMPLE_WIDTH;
	localparam int XW  = SW + 26;           // prescaled vector plus CORDIC growth
	localparam int SDW = 2 * SW + OUT_W;    // re, im and saturated intensity

	logic [2:0] mode_q;
	logic       en;

	// per-stage buses; index 0 is the front output
	cell_ctrl_t           ctrl [NUM_CELLS+1];
	logic signed [XW-1:0] cx   [NUM_CELLS+1];
	logic signed [XW-1:0] cy   [NUM_CELLS+1];
	logic signed [ZW-1:0] cz   [NUM_CELLS+1];
	logic [63:0]          crem [NUM_CELLS+1];
	logic [63:0]          cres [NUM_CELLS+1];
	logic [SDW-1:0]       side [NUM_CELLS+1];

	logic                 out_valid_q, out_last_q;
	logic [OUT_W-1:0]     out_value_q;

	// mode register; writes of unused codes leave it alone
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_RESET;
		end else if (cfg.valid && cfg.view_mode <= MODE_INTEN) begin
			mode_q <= cfg.view_mode;
		end
	end

	// one global advance: the pipe moves unless a result is stuck at the output
	assign en        = !out_valid_q || view.ready;
	assign pix.ready = en;

	cscv_front #(.SW(SW), .XW(XW), .SDW(SDW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (pix.valid),
		.re       (pix.real_part),
		.im       (pix.imag_part),
		.last     (pix.last_pixel),
		.mode     (mode_q),
		.ctrl_o   (ctrl[0]),
		.x_o      (cx[0]),
		.y_o      (cy[0]),
		.z_o      (cz[0]),
		.rem_o    (crem[0]),
		.res_o    (cres[0]),
		.side_o   (side[0])
	);

	// chain: cell k does CORDIC step k (first 30) and square-root digit k
	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		cscv_cell #(.IDX(k), .XW(XW), .SDW(SDW)) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctrl_i (ctrl[k]),
			.x_i    (cx[k]),
			.y_i    (cy[k]),
			.z_i    (cz[k]),
			.rem_i  (crem[k]),
			.res_i  (cres[k]),
			.side_i (side[k]),
			.ctrl_o (ctrl[k+1]),
			.x_o    (cx[k+1]),
			.y_o    (cy[k+1]),
			.z_o    (cz[k+1]),
			.rem_o  (crem[k+1]),
			.res_o  (cres[k+1]),
			.side_o (side[k+1])
		);
	end

	// output formatting
	cell_ctrl_t           fc;
	logic signed [SW-1:0] f_re, f_im;
	logic [OUT_W-1:0]     f_inten, f_ampl, f_phase, f_rnd, f_val;
	logic signed [ZW-1:0] f_z;

	always_comb begin
		fc      = ctrl[NUM_CELLS];
		f_re    = side[NUM_CELLS][SDW-1 -: SW];
		f_im    = side[NUM_CELLS][OUT_W +: SW];
		f_inten = side[NUM_CELLS][OUT_W-1:0];
		// Q.30 to Q3.13 with round half up
		f_z     = cz[NUM_CELLS] + 34'sd65536;
		f_phase = fc.zero ? '0 : {{16{f_z[ZW-1]}}, f_z[ZW-1:17]};
		// round to nearest: remainder above the root means the next integer
		f_rnd   = (crem[NUM_CELLS] > cres[NUM_CELLS]) ?
		          cres[NUM_CELLS][OUT_W-1:0] + 33'd1 : cres[NUM_CELLS][OUT_W-1:0];
		f_ampl  = (fc.sat || f_rnd > OUT_MAX) ? OUT_MAX : f_rnd;
		case (fc.mode)
			MODE_REAL:  f_val = OUT_W'(f_re);
			MODE_IMAG:  f_val = OUT_W'(f_im);
			MODE_PHASE: f_val = f_phase;
			MODE_AMPL:  f_val = f_ampl;
			default:    f_val = f_inten;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= fc.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_value_q <= f_val;
			out_last_q  <= fc.last;
		end
	end

	assign view.valid      = out_valid_q;
	assign view.view_value = out_value_q;
	assign view.last_out   = out_last_q;

endmodule

// ----- sv/cscv_front.sv -----
// ----------------------------------------------------------------------------
// cscv_front: input stages
// Squares and CORDIC quarter-turn prep (s1), sum of squares and flags (s2).
// ----------------------------------------------------------------------------
module cscv_front #(
	parameter int SW = 16,
	parameter int XW = SW + 26,
	parameter int SDW = 2 * SW + 33
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic signed [SW-1:0]   re,
	input  logic signed [SW-1:0]   im,
	input  logic                   last,
	input  logic [2:0]             mode,
	output cscv_pkg::cell_ctrl_t   ctrl_o,
	output logic signed [XW-1:0]   x_o,
	output logic signed [XW-1:0]   y_o,
	output logic signed [cscv_pkg::ZW-1:0] z_o,
	output logic [63:0]            rem_o,
	output logic [63:0]            res_o,
	output logic [SDW-1:0]         side_o
);
	import cscv_pkg::*;

	localparam int SQW = 2 * SW + 1;

	cell_ctrl_t            ctrl_s1, ctrl_s2;
	logic signed [SW-1:0]  re_s1, im_s1, re_s2, im_s2;
	logic [2*SW-1:0]       sqr_s1, sqi_s1;
	logic signed [XW-1:0]  x_s1, y_s1, x_s2, y_s2;
	logic signed [ZW-1:0]  z_s1, z_s2;
	logic [63:0]           rem_s2;
	logic [OUT_W-1:0]      inten_s2;

	logic signed [XW-1:0]  xp, yp, xn, yn;
	logic signed [ZW-1:0]  zn;
	logic signed [2*SW-1:0] pr, pi;
	logic [SQW-1:0]        sum;

	always_comb begin
		xp = XW'(re) <<< 24;
		yp = XW'(im) <<< 24;
		xn = xp;
		yn = yp;
		zn = '0;
		if (xp < 0) begin
			if (yp >= 0) begin
				xn = yp;
				yn = -xp;
				zn = HALF_PI_Q30;
			end else begin
				xn = -yp;
				yn = xp;
				zn = -HALF_PI_Q30;
			end
		end
		pr = re * re;
		pi = im * im;
		sum = SQW'(sqr_s1) + SQW'(sqi_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s1 <= '{valid: in_valid, last: last, mode: mode,
			             zero: (re == 0) && (im == 0), sat: 1'b0};
			ctrl_s2 <= '{valid: ctrl_s1.valid, last: ctrl_s1.last, mode: ctrl_s1.mode,
			             zero: ctrl_s1.zero, sat: (sum >> 48) != 0};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			re_s1    <= re;
			im_s1    <= im;
			sqr_s1   <= pr;
			sqi_s1   <= pi;
			x_s1     <= xn;
			y_s1     <= yn;
			z_s1     <= zn;
			re_s2    <= re_s1;
			im_s2    <= im_s1;
			x_s2     <= x_s1;
			y_s2     <= y_s1;
			z_s2     <= z_s1;
			rem_s2   <= 64'(sum) << 16;
			inten_s2 <= ((sum >> 32) != 0) ? OUT_MAX : OUT_W'(sum);
		end
	end

	assign ctrl_o = ctrl_s2;
	assign x_o    = x_s2;
	assign y_o    = y_s2;
	assign z_o    = z_s2;
	assign rem_o  = rem_s2;
	assign res_o  = '0;
	assign side_o = {re_s2, im_s2, inten_s2};

endmodule

// ----- sv/cscv_cell.sv -----
// ----------------------------------------------------------------------------
// cscv_cell: one chain cell
// One CORDIC vectoring step (first 30 cells) and one digit of the square root, registered.
// ----------------------------------------------------------------------------
module cscv_cell #(
	parameter int IDX = 0,
	parameter int XW = 42,
	parameter int SDW = 65
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  cscv_pkg::cell_ctrl_t   ctrl_i,
	input  logic signed [XW-1:0]   x_i,
	input  logic signed [XW-1:0]   y_i,
	input  logic signed [cscv_pkg::ZW-1:0] z_i,
	input  logic [63:0]            rem_i,
	input  logic [63:0]            res_i,
	input  logic [SDW-1:0]         side_i,
	output cscv_pkg::cell_ctrl_t   ctrl_o,
	output logic signed [XW-1:0]   x_o,
	output logic signed [XW-1:0]   y_o,
	output logic signed [cscv_pkg::ZW-1:0] z_o,
	output logic [63:0]            rem_o,
	output logic [63:0]            res_o,
	output logic [SDW-1:0]         side_o
);
	import cscv_pkg::*;

	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * IDX);

	cell_ctrl_t           ctrl_q;
	logic signed [XW-1:0] x_q, y_q, xn, yn;
	logic signed [ZW-1:0] z_q, zn;
	logic [63:0]          rem_q, res_q, rem_n, res_n, trial;
	logic [SDW-1:0]       side_q;

	generate
		if (IDX < CORDIC_STEPS) begin : g_rot
			localparam logic signed [ZW-1:0] ANG = ZW'(ATAN_Q30[IDX]);
			always_comb begin
				if (y_i > 0) begin
					xn = x_i + (y_i >>> IDX);
					yn = y_i - (x_i >>> IDX);
					zn = z_i + ANG;
				end else begin
					xn = x_i - (y_i >>> IDX);
					yn = y_i + (x_i >>> IDX);
					zn = z_i - ANG;
				end
			end
		end else begin : g_pass
			assign xn = x_i;
			assign yn = y_i;
			assign zn = z_i;
		end
	endgenerate

	always_comb begin
		trial = res_i + BIT;
		if (rem_i >= trial) begin
			rem_n = rem_i - trial;
			res_n = (res_i >> 1) + BIT;
		end else begin
			rem_n = rem_i;
			res_n = res_i >> 1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else if (en) begin
			ctrl_q <= ctrl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_q    <= xn;
			y_q    <= yn;
			z_q    <= zn;
			rem_q  <= rem_n;
			res_q  <= res_n;
			side_q <= side_i;
		end
	end

	assign ctrl_o = ctrl_q;
	assign x_o    = x_q;
	assign y_o    = y_q;
	assign z_o    = z_q;
	assign rem_o  = rem_q;
	assign res_o  = res_q;
	assign side_o = side_q;

endmodule

// ----- sv/cscv_checker.sv -----
// ----------------------------------------------------------------------------
// cscv_checker: port-level checks
// Output hold under stall, flow control coupling and config acceptance.
// ----------------------------------------------------------------------------
module cscv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        pix_ready,
	input logic        view_valid,
	input logic        view_ready,
	input logic [32:0] view_value,
	input logic        cfg_ready
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		view_valid && !view_ready |=> view_valid && $stable(view_value))
		else $error("stalled view request changed");

	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(view_valid) |-> $past(view_ready))
		else $error("view request withdrawn without being taken");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		pix_ready == (!view_valid || view_ready))
		else $error("input ready not tied to output space");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("mode write not accepted");

endmodule

bind complex_sample_to_real_view_core cscv_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.pix_ready  (pix.ready),
	.view_valid (view.valid),
	.view_ready (view.ready),
	.view_value (view.view_value),
	.cfg_ready  (cfg.ready)
);
